FILE: hdl/assert_macros.svh
// Assertion helpers for the cache block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

FILE: hdl/lfu_pkg.sv
package lfu_pkg;
	localparam int Capacity = 16;
	localparam int IdxW = 4;
	localparam int KeyW = 32;
	localparam int ValW = 32;
	localparam int CntW = 32;
	localparam int CapW = 5;
	localparam logic [CapW-1:0] CapReset = 5'd16;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_LOOKUP = 6'b000010,
		ST_SEARCH = 6'b000100,
		ST_UPDATE = 6'b001000,
		ST_INSERT = 6'b010000,
		ST_OUT    = 6'b100000
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic lookup_step;
		logic search_step;
		logic do_hit;
		logic do_insert;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic found;
		logic is_put;
		logic need_evict;
	} sts_t;
endpackage

FILE: hdl/lfu_cache_lru_tiebreak.sv
// Fully associative 16-entry key-value cache with least-frequently-used
// replacement and least-recently-used tie-break. One item is taken at a
// time: a lookup scans all 16 entries one per cycle, and a put miss on a
// full cache scans them again for the victim. A new input beat is accepted
// only once the result of the last item has been taken, and the result
// waits while out_stall is high. The capacity register must be written
// only while idle; the block itself does not enforce it.
`include "assert_macros.svh"
module lfu_cache_lru_tiebreak (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            command,
	input  logic [lfu_pkg::KeyW-1:0]        key,
	input  logic signed [lfu_pkg::ValW-1:0] value,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            hit,
	output logic signed [lfu_pkg::ValW-1:0] read_value,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lfu_pkg::CapW-1:0]        cfg_data
);
	lfu_pkg::cmd_t cmd;
	lfu_pkg::sts_t sts;
	logic [lfu_pkg::CapW-1:0] cap_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lfu_pkg::CapReset;
		end else if (cfg_valid && cfg_ready) begin
			cap_q <= cfg_data;
		end
	end

	lfu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	lfu_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .command(command),
		.key(key), .value(value), .cap_q(cap_q), .hit(hit), .read_value(read_value)
	);

	`CHK_IMPL(a_no_accept_busy, clk, arst_n, out_valid, in_stall, "input taken while result pending")
	`CHK_NEXT(a_accept_starts, clk, arst_n, in_valid && !in_stall, in_stall, "accept did not start work")
	`CHK_IMPL(a_put_no_data, clk, arst_n, out_valid && !hit, read_value == '0, "miss returned data")
endmodule

FILE: hdl/lfu_ctrl.sv
module lfu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	output logic           out_valid,
	input  logic           out_stall,
	input  lfu_pkg::sts_t  sts,
	output lfu_pkg::cmd_t  cmd
);
	lfu_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfu_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall  = (state_q != lfu_pkg::ST_IDLE);
	assign out_valid = (state_q == lfu_pkg::ST_OUT);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			lfu_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					cmd.scan_clr = 1'b1;
					state_d = lfu_pkg::ST_LOOKUP;
				end
			end
			lfu_pkg::ST_LOOKUP: begin
				cmd.lookup_step = 1'b1;
				if (sts.scan_last) begin
					state_d = lfu_pkg::ST_UPDATE;
				end
			end
			lfu_pkg::ST_UPDATE: begin
				cmd.scan_clr = 1'b1;
				if (sts.found) begin
					cmd.do_hit = 1'b1;
					state_d = lfu_pkg::ST_OUT;
				end else if (!sts.is_put) begin
					state_d = lfu_pkg::ST_OUT;
				end else if (sts.need_evict) begin
					state_d = lfu_pkg::ST_SEARCH;
				end else begin
					state_d = lfu_pkg::ST_INSERT;
				end
			end
			lfu_pkg::ST_SEARCH: begin
				cmd.search_step = 1'b1;
				if (sts.scan_last) begin
					state_d = lfu_pkg::ST_INSERT;
				end
			end
			lfu_pkg::ST_INSERT: begin
				cmd.do_insert = 1'b1;
				state_d = lfu_pkg::ST_OUT;
			end
			lfu_pkg::ST_OUT: begin
				if (!out_stall) begin
					state_d = lfu_pkg::ST_IDLE;
				end
			end
			default: state_d = lfu_pkg::ST_IDLE;
		endcase
	end
endmodule

FILE: hdl/lfu_dpath.sv
module lfu_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lfu_pkg::cmd_t                 cmd,
	output lfu_pkg::sts_t                 sts,
	input  logic                          command,
	input  logic [lfu_pkg::KeyW-1:0]      key,
	input  logic signed [lfu_pkg::ValW-1:0] value,
	input  logic [lfu_pkg::CapW-1:0]      cap_q,
	output logic                          hit,
	output logic signed [lfu_pkg::ValW-1:0] read_value
);
	localparam int Cap = lfu_pkg::Capacity;
	localparam int IW = lfu_pkg::IdxW;

	logic [Cap-1:0]                 valid_q;
	logic [lfu_pkg::KeyW-1:0]       key_mem [Cap];
	logic [lfu_pkg::ValW-1:0]       data_mem [Cap];
	logic [lfu_pkg::CntW-1:0]       cnt_mem [Cap];
	logic [IW-1:0]                  rank_q [Cap];
	logic [lfu_pkg::CapW-1:0]       occ_q;

	logic                           put_q;
	logic [lfu_pkg::KeyW-1:0]       key_q;
	logic [lfu_pkg::ValW-1:0]       val_q;
	logic [IW-1:0]                  ptr_q;
	logic                           found_q;
	logic [IW-1:0]                  slot_q;
	logic                           vic_ok_q;
	logic [IW-1:0]                  vic_q;
	logic [lfu_pkg::CntW-1:0]       vic_cnt_q;
	logic [IW-1:0]                  vic_rank_q;
	logic                           hit_q;
	logic [lfu_pkg::ValW-1:0]       rv_q;

	logic [lfu_pkg::CapW-1:0] eff_cap;
	logic [Cap-1:0]           free_v;
	logic [Cap-1:0]           free_v_ev;
	logic [IW-1:0]            free_idx;
	logic                     better;

	always_comb begin
		eff_cap = cap_q;
		if (cap_q == '0) eff_cap = lfu_pkg::CapW'(1);
		if (cap_q > lfu_pkg::CapW'(Cap)) eff_cap = lfu_pkg::CapW'(Cap);
	end

	assign better = !vic_ok_q || (cnt_mem[ptr_q] < vic_cnt_q) ||
		(cnt_mem[ptr_q] == vic_cnt_q && rank_q[ptr_q] > vic_rank_q);

	always_comb begin
		free_v_ev = ~valid_q;
		if (vic_ok_q) free_v_ev[vic_q] = 1'b1;
		free_idx = '0;
		for (int i = Cap - 1; i >= 0; i--) begin
			if (free_v_ev[i]) free_idx = IW'(i);
		end
		free_v = free_v_ev;
	end

	assign sts.scan_last  = (ptr_q == IW'(Cap - 1));
	assign sts.found      = found_q;
	assign sts.is_put     = put_q;
	assign sts.need_evict = (occ_q >= eff_cap);
	assign hit = hit_q;
	assign read_value = rv_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			put_q <= command;
			key_q <= key;
			val_q <= value;
		end
		if (cmd.lookup_step && valid_q[ptr_q] && key_mem[ptr_q] == key_q && !found_q) begin
			slot_q <= ptr_q;
		end
		if (cmd.search_step && valid_q[ptr_q] && better) begin
			vic_q <= ptr_q;
			vic_cnt_q <= cnt_mem[ptr_q];
			vic_rank_q <= rank_q[ptr_q];
		end
		if (cmd.do_hit) begin
			if (cnt_mem[slot_q] != '1) cnt_mem[slot_q] <= cnt_mem[slot_q] + 1'b1;
			if (put_q) data_mem[slot_q] <= val_q;
		end
		if (cmd.do_insert && free_v != '0) begin
			key_mem[free_idx]  <= key_q;
			data_mem[free_idx] <= val_q;
			cnt_mem[free_idx]  <= lfu_pkg::CntW'(1);
		end
		if (cmd.scan_clr && cmd.load) begin
			rv_q <= '0;
		end else if (cmd.do_hit) begin
			rv_q <= put_q ? '0 : data_mem[slot_q];
		end
		for (int i = 0; i < Cap; i++) begin
			if (cmd.do_hit) begin
				if (IW'(i) == slot_q) rank_q[i] <= '0;
				else if (valid_q[i] && rank_q[i] < rank_q[slot_q]) rank_q[i] <= rank_q[i] + 1'b1;
			end
			if (cmd.do_insert && free_v != '0) begin
				if (IW'(i) == free_idx) begin
					rank_q[i] <= '0;
				end else if (valid_q[i] && !(vic_ok_q && IW'(i) == vic_q)) begin
					if (vic_ok_q && rank_q[i] > vic_rank_q) rank_q[i] <= rank_q[i];
					else rank_q[i] <= rank_q[i] + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			occ_q    <= '0;
			ptr_q    <= '0;
			found_q  <= 1'b0;
			vic_ok_q <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			if (cmd.scan_clr) ptr_q <= '0;
			else if (cmd.lookup_step || cmd.search_step) ptr_q <= ptr_q + 1'b1;
			if (cmd.load) begin
				found_q  <= 1'b0;
				vic_ok_q <= 1'b0;
				hit_q    <= 1'b0;
			end
			if (cmd.lookup_step && valid_q[ptr_q] && key_mem[ptr_q] == key_q) found_q <= 1'b1;
			if (cmd.search_step && valid_q[ptr_q] && better) vic_ok_q <= 1'b1;
			if (cmd.do_hit) hit_q <= 1'b1;
			if (cmd.do_insert && free_v != '0) begin
				valid_q <= ~free_v | (Cap'(1) << free_idx);
				if (!vic_ok_q) occ_q <= occ_q + 1'b1;
			end
		end
	end
endmodule
